// ===== rtl/core/fsh_pkg.sv =====
// fsh_pkg: shared types, constants and helpers for the fuzzy subsequence highlighter
// no dependencies; used by every other file of the block
package fsh_pkg;

	localparam int CHAR_W       = 8;
	localparam int LEN_W        = 10;
	localparam int TL_W         = 6;
	localparam int CNT_W        = 10;
	localparam int WORD_W       = 64;
	localparam int NUM_WORDS    = 4;
	localparam int TERM_SLOTS   = 32;
	localparam int TERM_BITS    = NUM_WORDS * WORD_W;
	localparam int TERM_IDX_W   = $clog2(TERM_SLOTS);
	localparam int CFG_IDX_W    = 3;
	localparam int MIN_RUN      = 2;
	localparam int RQ_DEPTH     = 4;

	localparam int MAX_TERM_LEN_DEF   = 32;
	localparam int MAX_SOURCE_LEN_DEF = 1023;

	localparam logic [TL_W-1:0]  TERM_LEN_RESET = TL_W'(2);
	localparam logic [CNT_W-1:0] SAT10          = {CNT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TERM_LENGTH = 3'd0,
		CFG_TERM_WORD_0 = 3'd1,
		CFG_TERM_WORD_1 = 3'd2,
		CFG_TERM_WORD_2 = 3'd3,
		CFG_TERM_WORD_3 = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RUN_NONE = 2'd0,
		RUN_ONE  = 2'd1,
		RUN_TWO  = 2'd2
	} run_t;

	// running state of one source string
	typedef struct packed {
		logic [TL_W-1:0]   term_pos;
		run_t              run;
		logic [CHAR_W-1:0] held;
		logic [LEN_W-1:0]  latched_len;
		logic              term_finished;
		logic              match_found;
		logic [CNT_W-1:0]  frags;
		logic [CNT_W-1:0]  first_pos;
		logic              first_valid;
		logic [CNT_W-1:0]  unmatched;
	} st_t;

	// one result beat
	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              open_before;
		logic              close_before;
		logic              close_after;
		logic              final_result;
		logic              matched;
		logic [CNT_W-1:0]  fragment_count;
		logic [CNT_W-1:0]  first_frag_pos;
		logic [CNT_W-1:0]  unmatched_count;
	} res_t;

	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		inc_sat = (v < SAT10) ? v + CNT_W'(1) : SAT10;
	endfunction

	function automatic res_t mk_res(input logic [CHAR_W-1:0] c, input logic ob,
			input logic cb, input logic ca);
		res_t r;
		r = '0;
		r.out_char     = c;
		r.open_before  = ob;
		r.close_before = cb;
		r.close_after  = ca;
		mk_res = r;
	endfunction

endpackage

// ===== rtl/core/fsh_if.sv =====
// fsh_if: valid/ready channel interfaces for source characters and result beats
// depends on fsh_pkg for field widths
interface fsh_in_if;
	logic                          valid;
	logic                          ready;
	logic [fsh_pkg::CHAR_W-1:0]    source_char;
	logic [fsh_pkg::LEN_W-1:0]     source_length;
	logic                          last_char;

	modport source (output valid, source_char, source_length, last_char, input ready);
	modport sink (input valid, source_char, source_length, last_char, output ready);
	modport monitor (input valid, ready, source_char, source_length, last_char);
endinterface

interface fsh_out_if;
	logic                          valid;
	logic                          ready;
	logic [fsh_pkg::CHAR_W-1:0]    out_char;
	logic                          open_before;
	logic                          close_before;
	logic                          close_after;
	logic                          final_result;
	logic                          matched;
	logic [fsh_pkg::CNT_W-1:0]     fragment_count;
	logic [fsh_pkg::CNT_W-1:0]     first_frag_pos;
	logic [fsh_pkg::CNT_W-1:0]     unmatched_count;

	modport source (output valid, out_char, open_before, close_before, close_after,
		final_result, matched, fragment_count, first_frag_pos, unmatched_count,
		input ready);
	modport sink (input valid, out_char, open_before, close_before, close_after,
		final_result, matched, fragment_count, first_frag_pos, unmatched_count,
		output ready);
	modport monitor (input valid, ready, out_char, open_before, close_before, close_after,
		final_result, matched, fragment_count, first_frag_pos, unmatched_count);
endinterface

// ===== rtl/core/fsh_step.sv =====
// fsh_step: next-state and result logic for one source character
// depends on fsh_pkg; purely combinational, sits between the input and result registers
module fsh_step #(
	parameter int MAX_TERM_LEN   = fsh_pkg::MAX_TERM_LEN_DEF,
	parameter int MAX_SOURCE_LEN = fsh_pkg::MAX_SOURCE_LEN_DEF,
	localparam int PosW          = $clog2(MAX_SOURCE_LEN + 1)
) (
	input  logic [fsh_pkg::CHAR_W-1:0]    source_char,
	input  logic [fsh_pkg::LEN_W-1:0]     source_length,
	input  logic                          last_char,
	input  logic [fsh_pkg::TL_W-1:0]      term_length,
	input  logic [fsh_pkg::TERM_BITS-1:0] term_flat,
	input  fsh_pkg::st_t                  st,
	input  logic [PosW-1:0]               pos,
	output fsh_pkg::st_t                  st_nx,
	output logic [PosW-1:0]               pos_nx,
	output fsh_pkg::res_t                 res0,
	output fsh_pkg::res_t                 res1,
	output logic [1:0]                    res_cnt
);

	fsh_pkg::st_t              nx;
	fsh_pkg::res_t             rr [2];
	logic [1:0]                n;
	logic [1:0]                idx;
	logic [fsh_pkg::LEN_W-1:0] lat;
	logic                      active;
	logic [fsh_pkg::CHAR_W-1:0] tc;
	logic [fsh_pkg::TERM_IDX_W-1:0] tsel;

	always_comb begin
		nx    = st;
		rr[0] = '0;
		rr[1] = '0;
		n     = 2'd0;
		idx   = 2'd0;
		lat   = (pos == '0) ? source_length : st.latched_len;
		nx.latched_len = lat;
		active = (term_length >= fsh_pkg::TL_W'(fsh_pkg::MIN_RUN))
			&& (term_length <= fsh_pkg::TL_W'(fsh_pkg::TERM_SLOTS))
			&& (7'(term_length) <= 7'(MAX_TERM_LEN))
			&& (lat > fsh_pkg::LEN_W'(term_length));
		tsel = st.term_pos[fsh_pkg::TERM_IDX_W-1:0];
		tc   = term_flat[{tsel, 3'b000} +: fsh_pkg::CHAR_W];

		if (!active || st.term_finished) begin
			rr[n[0]] = fsh_pkg::mk_res(source_char, 1'b0, 1'b0, 1'b0);
			n = n + 2'd1;
			if (st.term_finished && st.match_found)
				nx.unmatched = fsh_pkg::inc_sat(st.unmatched);
		end else begin
			if (fsh_pkg::fold(tc) == fsh_pkg::fold(source_char)) begin
				nx.term_pos = st.term_pos + fsh_pkg::TL_W'(1);
				case (st.run)
					fsh_pkg::RUN_NONE: begin
						nx.run  = fsh_pkg::RUN_ONE;
						nx.held = source_char;
					end
					fsh_pkg::RUN_ONE: begin
						nx.run = fsh_pkg::RUN_TWO;
						rr[0]  = fsh_pkg::mk_res(st.held, 1'b1, 1'b0, 1'b0);
						rr[1]  = fsh_pkg::mk_res(source_char, 1'b0, 1'b0, 1'b0);
						n      = 2'd2;
						nx.frags = fsh_pkg::inc_sat(st.frags);
						if (!st.first_valid) begin
							nx.first_valid = 1'b1;
							nx.first_pos   = (pos == '0) ? '0 :
								fsh_pkg::CNT_W'(32'(pos) - 32'd1);
						end
					end
					default: begin
						rr[0] = fsh_pkg::mk_res(source_char, 1'b0, 1'b0, 1'b0);
						n     = 2'd1;
					end
				endcase
			end else begin
				nx.unmatched = fsh_pkg::inc_sat(st.unmatched);
				if (st.run == fsh_pkg::RUN_ONE) begin
					// held char released, both count as unmatched
					nx.unmatched = fsh_pkg::inc_sat(nx.unmatched);
					nx.term_pos  = st.term_pos - fsh_pkg::TL_W'(1);
					rr[0] = fsh_pkg::mk_res(st.held, 1'b0, 1'b0, 1'b0);
					rr[1] = fsh_pkg::mk_res(source_char, 1'b0, 1'b0, 1'b0);
					n     = 2'd2;
				end else if (st.run == fsh_pkg::RUN_TWO) begin
					rr[0] = fsh_pkg::mk_res(source_char, 1'b0, 1'b1, 1'b0);
					n     = 2'd1;
				end else begin
					rr[0] = fsh_pkg::mk_res(source_char, 1'b0, 1'b0, 1'b0);
					n     = 2'd1;
				end
				nx.run = fsh_pkg::RUN_NONE;
			end

			if (nx.term_pos >= term_length) begin
				nx.term_finished = 1'b1;
				if (nx.run == fsh_pkg::RUN_TWO) begin
					if (n != 2'd0) begin
						idx = n - 2'd1;
						rr[idx[0]].close_after = 1'b1;
					end
					nx.match_found = 1'b1;
				end else if (nx.run == fsh_pkg::RUN_ONE && nx.first_valid) begin
					// lone last char closes the term after an earlier fragment
					rr[n[0]] = fsh_pkg::mk_res(nx.held, 1'b1, 1'b0, 1'b1);
					n = n + 2'd1;
					nx.frags = fsh_pkg::inc_sat(nx.frags);
					nx.match_found = 1'b1;
				end else if (nx.run == fsh_pkg::RUN_ONE) begin
					rr[n[0]] = fsh_pkg::mk_res(nx.held, 1'b0, 1'b0, 1'b0);
					n = n + 2'd1;
				end
				nx.run = fsh_pkg::RUN_NONE;
			end
		end

		pos_nx = (pos < PosW'(MAX_SOURCE_LEN)) ? pos + PosW'(1) : pos;

		if (last_char) begin
			if (nx.run == fsh_pkg::RUN_ONE) begin
				rr[n[0]] = fsh_pkg::mk_res(nx.held, 1'b0, 1'b0, 1'b0);
				n = n + 2'd1;
			end
			idx = n - 2'd1;
			rr[idx[0]].final_result = 1'b1;
			if (nx.match_found) begin
				rr[idx[0]].matched         = 1'b1;
				rr[idx[0]].fragment_count  = nx.frags;
				rr[idx[0]].first_frag_pos  = nx.first_pos;
				rr[idx[0]].unmatched_count = nx.unmatched;
			end else begin
				rr[idx[0]].matched         = 1'b0;
				rr[idx[0]].fragment_count  = fsh_pkg::SAT10;
				rr[idx[0]].first_frag_pos  = fsh_pkg::SAT10;
				rr[idx[0]].unmatched_count = fsh_pkg::SAT10;
			end
			nx     = '0;
			pos_nx = '0;
		end
	end

	assign st_nx   = nx;
	assign res0    = rr[0];
	assign res1    = rr[1];
	assign res_cnt = n;

endmodule

// ===== rtl/core/fsh_rq.sv =====
// fsh_rq: small result queue, takes up to two beats per cycle, gives one
// depends on fsh_pkg for the result type and depth
module fsh_rq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_cnt,
	input  fsh_pkg::res_t push0,
	input  fsh_pkg::res_t push1,
	input  logic          pop,
	output fsh_pkg::res_t head,
	output logic          not_empty,
	output logic          room2
);

	localparam int PtrW = $clog2(fsh_pkg::RQ_DEPTH);

	fsh_pkg::res_t   mem_q [fsh_pkg::RQ_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   cnt_q;
	logic            do_pop;
	logic [PtrW-1:0] wr_nxt;

	assign do_pop    = pop && not_empty;
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= (PtrW + 1)'(fsh_pkg::RQ_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];
	assign wr_nxt    = wr_ptr_q + PtrW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			cnt_q <= cnt_q + (PtrW + 1)'(push_cnt) - (PtrW + 1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_nxt] <= push1;
	end

endmodule

// ===== rtl/core/fuzzy_subsequence_highlighter_unit.sv =====
// fuzzy_subsequence_highlighter_unit: top level, config registers, input stage, string state
// depends on fsh_pkg, fsh_if, fsh_step and fsh_rq
//
// Takes one source character per cycle while src.ready is high and matches it against the
// configured term (in-order, ASCII case-insensitive runs of two or more, or a lone last
// term character after an earlier run). Every character leaves once on res with highlight
// flags; the last beat of a string carries the summary. A character is registered, stepped
// through one level of compare-and-count logic and written into a four-entry result queue.
// Throughput is one character per cycle while the queue has room for two beats; a character
// that completes a held run releases two beats, and res drains one beat a cycle while
// res.ready is high. Write configuration only while no string is in flight.
module fuzzy_subsequence_highlighter_unit #(
	parameter int MAX_TERM_LEN   = fsh_pkg::MAX_TERM_LEN_DEF,
	parameter int MAX_SOURCE_LEN = fsh_pkg::MAX_SOURCE_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fsh_in_if.sink                         src,
	fsh_out_if.source                      res,
	input  logic                           cfg_we,
	input  logic [fsh_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fsh_pkg::WORD_W-1:0]     cfg_data
);

	localparam int PosW = $clog2(MAX_SOURCE_LEN + 1);

	logic [fsh_pkg::TL_W-1:0]    term_length_q;
	logic [fsh_pkg::WORD_W-1:0]  term_word_q [fsh_pkg::NUM_WORDS];
	logic [fsh_pkg::TERM_BITS-1:0] term_flat;

	logic                        valid_s1;
	logic [fsh_pkg::CHAR_W-1:0]  char_s1;
	logic [fsh_pkg::LEN_W-1:0]   len_s1;
	logic                        last_s1;

	fsh_pkg::st_t                st_q;
	fsh_pkg::st_t                st_nx;
	logic [PosW-1:0]             pos_q;
	logic [PosW-1:0]             pos_nx;

	fsh_pkg::res_t               res0;
	fsh_pkg::res_t               res1;
	fsh_pkg::res_t               head;
	logic [1:0]                  res_cnt;
	logic                        room2;
	logic                        advance;
	logic                        accept;

	assign term_flat = {term_word_q[3], term_word_q[2], term_word_q[1], term_word_q[0]};
	assign advance   = valid_s1 && room2;
	assign src.ready = !valid_s1 || room2;
	assign accept    = src.valid && src.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_length_q <= fsh_pkg::TERM_LEN_RESET;
			for (int i = 0; i < fsh_pkg::NUM_WORDS; i++)
				term_word_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fsh_pkg::CFG_TERM_LENGTH: term_length_q  <= cfg_data[fsh_pkg::TL_W-1:0];
				fsh_pkg::CFG_TERM_WORD_0: term_word_q[0] <= cfg_data;
				fsh_pkg::CFG_TERM_WORD_1: term_word_q[1] <= cfg_data;
				fsh_pkg::CFG_TERM_WORD_2: term_word_q[2] <= cfg_data;
				fsh_pkg::CFG_TERM_WORD_3: term_word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
			pos_q    <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				st_q  <= st_nx;
				pos_q <= pos_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= src.source_char;
			len_s1  <= src.source_length;
			last_s1 <= src.last_char;
		end
	end

	fsh_step #(
		.MAX_TERM_LEN   (MAX_TERM_LEN),
		.MAX_SOURCE_LEN (MAX_SOURCE_LEN)
	) u_step (
		.source_char   (char_s1),
		.source_length (len_s1),
		.last_char     (last_s1),
		.term_length   (term_length_q),
		.term_flat     (term_flat),
		.st            (st_q),
		.pos           (pos_q),
		.st_nx         (st_nx),
		.pos_nx        (pos_nx),
		.res0          (res0),
		.res1          (res1),
		.res_cnt       (res_cnt)
	);

	fsh_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (advance ? res_cnt : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.pop       (res.ready),
		.head      (head),
		.not_empty (res.valid),
		.room2     (room2)
	);

	assign res.out_char        = head.out_char;
	assign res.open_before     = head.open_before;
	assign res.close_before    = head.close_before;
	assign res.close_after     = head.close_after;
	assign res.final_result    = head.final_result;
	assign res.matched         = head.matched;
	assign res.fragment_count  = head.fragment_count;
	assign res.first_frag_pos  = head.first_frag_pos;
	assign res.unmatched_count = head.unmatched_count;

endmodule

// ===== rtl/core/fsh_checker.sv =====
// fsh_checker: port-level checks on the highlighter, bound to the top level
// depends on fsh_pkg; the bind below attaches it to fuzzy_subsequence_highlighter_unit
module fsh_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       src_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [fsh_pkg::CHAR_W-1:0] res_out_char,
	input logic                       res_final_result,
	input logic                       res_matched,
	input logic [fsh_pkg::CNT_W-1:0]  res_fragment_count,
	input logic [fsh_pkg::CNT_W-1:0]  res_first_frag_pos,
	input logic [fsh_pkg::CNT_W-1:0]  res_unmatched_count
);

	// a waiting result beat stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_out_char) && $stable(res_final_result))
		else $error("stalled result beat changed");

	// nothing queued means the input stage cannot be blocked
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> src_ready)
		else $error("input stalled with an empty result queue");

	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_final_result |-> !res_matched && res_fragment_count == '0
			&& res_first_frag_pos == '0 && res_unmatched_count == '0)
		else $error("summary fields set on a non-final beat");

	a_nomatch_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_final_result && !res_matched |->
			res_fragment_count == fsh_pkg::SAT10 && res_first_frag_pos == fsh_pkg::SAT10
			&& res_unmatched_count == fsh_pkg::SAT10)
		else $error("no-match summary not saturated");

endmodule

bind fuzzy_subsequence_highlighter_unit fsh_checker u_fsh_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.src_ready           (src.ready),
	.res_valid           (res.valid),
	.res_ready           (res.ready),
	.res_out_char        (res.out_char),
	.res_final_result    (res.final_result),
	.res_matched         (res.matched),
	.res_fragment_count  (res.fragment_count),
	.res_first_frag_pos  (res.first_frag_pos),
	.res_unmatched_count (res.unmatched_count)
);
